// ===== src/tff_pkg.sv =====
// Shared constants for the telemetry field framer.
`default_nettype none

package tff_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned IdW    = 8;
  localparam int unsigned ValW   = 16;
  localparam int unsigned InDataW = 24;  // field_id and field_value, whole bytes
  localparam int unsigned SeqIdxW = 3;   // up to six bytes per request
  localparam int unsigned MaxBytes = 6;

  localparam logic [ByteW-1:0] HdrByte  = 8'h5E;
  localparam logic [ByteW-1:0] EscByte  = 8'h5D;
  localparam logic [ByteW-1:0] EscOfHdr = 8'h3E;
  localparam logic [ByteW-1:0] EscOfEsc = 8'h3D;

  // request kinds carried on tuser
  localparam logic OpData = 1'b0;
  localparam logic OpTail = 1'b1;

endpackage

`default_nettype wire

// ===== src/telemetry_field_framer_stuffing.sv =====
// Telemetry framer: turns data-field and frame-tail requests into a stuffed byte stream.
//
// Input stream (s_axis): one request per handshake. tuser selects the kind:
// a data field (tuser = 0) carries an 8-bit identifier and a 16-bit value in
// tdata; a frame tail (tuser = 1) ignores tdata.
// Output stream (m_axis): one byte per handshake. A data field gives 0x5E,
// the identifier as is, then the value low byte and high byte, each with
// 0x5E sent as 0x5D 0x3E and 0x5D as 0x5D 0x3D: four to six bytes. A tail
// gives a single 0x5E. tlast marks the final byte of each request.
// An accepted request is first captured in the held-request register, and its
// bytes then pass through the output register. Throughput: one output byte per cycle
// while the receiver does not stall; the byte sequencer walks the held request, and
// the next request is taken in the cycle its predecessor's final byte moves into the
// output register, so no bubbles appear.
// Reset clears the held-request and output valid flags and the sequencer index only.
// While the receiver stalls, the output byte holds and the sequencer waits;
// the input is ready while no request is held or as the held request's final byte advances.
`default_nettype none

module telemetry_field_framer_stuffing (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         s_axis_tvalid,
  output      logic                         s_axis_tready,
  input  wire logic [tff_pkg::InDataW-1:0]  s_axis_tdata,  // [7:0] field_id, [23:8] field_value
  input  wire logic                         s_axis_tuser,  // [0] op
  output      logic                         m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  output      logic [tff_pkg::ByteW-1:0]    m_axis_tdata,  // [7:0] out_byte
  output      logic                         m_axis_tlast   // last_of_item
);
  import tff_pkg::*;

  logic                in_vld_q, in_vld_d;
  logic                in_op_q;
  logic [IdW-1:0]      in_id_q;
  logic [ValW-1:0]     in_val_q;
  logic [SeqIdxW-1:0]  idx_q, idx_d;
  logic                out_vld_q, out_vld_d;
  logic [ByteW-1:0]    out_byte_q;
  logic                out_last_q;

  logic                s_acc;
  logic                advance;
  logic                is_last;
  logic [ByteW-1:0]    lo_b, hi_b;
  logic                lo_esc, hi_esc;
  logic [ByteW-1:0]    lo_first, lo_code, hi_first, hi_code;
  logic [SeqIdxW-1:0]  last_idx;
  logic [ByteW-1:0]    cur_byte;

  assign lo_b   = in_val_q[ByteW-1:0];
  assign hi_b   = in_val_q[ValW-1:ByteW];
  assign lo_esc = (lo_b == HdrByte) || (lo_b == EscByte);
  assign hi_esc = (hi_b == HdrByte) || (hi_b == EscByte);

  // first byte of each value byte, and the code byte that follows an escape
  assign lo_first = lo_esc ? EscByte : lo_b;
  assign hi_first = hi_esc ? EscByte : hi_b;
  assign lo_code  = (lo_b == HdrByte) ? EscOfHdr : EscOfEsc;
  assign hi_code  = (hi_b == HdrByte) ? EscOfHdr : EscOfEsc;

  always_comb begin
    if (in_op_q == OpTail) begin
      last_idx = '0;
    end else begin
      last_idx = SeqIdxW'(3) + SeqIdxW'(lo_esc) + SeqIdxW'(hi_esc);
    end
  end

  always_comb begin
    case (idx_q)
      3'd0:    cur_byte = HdrByte;
      3'd1:    cur_byte = in_id_q;
      3'd2:    cur_byte = lo_first;
      3'd3:    cur_byte = lo_esc ? lo_code : hi_first;
      3'd4:    cur_byte = lo_esc ? hi_first : hi_code;
      3'd5:    cur_byte = hi_code;
      default: cur_byte = HdrByte;
    endcase
  end

  assign is_last       = (idx_q == last_idx);
  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || (advance && is_last);
  assign s_acc         = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_vld_d = in_vld_q;
    idx_d    = idx_q;
    if (advance) begin
      idx_d = is_last ? '0 : idx_q + SeqIdxW'(1);
      if (is_last) begin
        in_vld_d = 1'b0;
      end
    end
    if (s_acc) begin
      in_vld_d = 1'b1;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      idx_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      idx_q     <= idx_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      in_op_q  <= s_axis_tuser;
      in_id_q  <= s_axis_tdata[IdW-1:0];
      in_val_q <= s_axis_tdata[IdW+ValW-1:IdW];
    end
    if (advance) begin
      out_byte_q <= cur_byte;
      out_last_q <= is_last;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_byte_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

// ===== src/tff_checker.sv =====
// Port-level checker for the telemetry framer, bound to the framer module.
`default_nettype none

module tff_checker (
  input wire logic                         clk_i,
  input wire logic                         rst_ni,
  input wire logic                         m_axis_tvalid,
  input wire logic                         m_axis_tready,
  input wire logic [tff_pkg::ByteW-1:0]    m_axis_tdata,
  input wire logic                         m_axis_tlast
);
  import tff_pkg::*;

  logic                out_acc;
  logic                at_start_q;  // next byte opens a request
  logic                esc_q;       // previous byte was a stuffing escape
  logic [SeqIdxW-1:0]  pos_q;

  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      at_start_q <= 1'b1;
      esc_q      <= 1'b0;
      pos_q      <= '0;
    end else if (out_acc) begin
      at_start_q <= m_axis_tlast;
      esc_q      <= !m_axis_tlast && (pos_q >= SeqIdxW'(2)) && (m_axis_tdata == EscByte)
                    && !esc_q;
      pos_q      <= m_axis_tlast ? '0 : pos_q + SeqIdxW'(1);
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output byte changed while stalled");

  a_header_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && at_start_q |-> m_axis_tdata == HdrByte)
    else $error("request did not open with the header byte");

  a_escape_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && esc_q |-> (m_axis_tdata == EscOfHdr) || (m_axis_tdata == EscOfEsc))
    else $error("escape not followed by a stuffing code");

  a_max_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && (pos_q == SeqIdxW'(MaxBytes - 1)) |-> m_axis_tlast)
    else $error("request produced more than six bytes");

  a_tail_short: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && m_axis_tlast && !at_start_q |-> pos_q >= SeqIdxW'(3))
    else $error("data field ended before its value bytes");

endmodule

bind telemetry_field_framer_stuffing tff_checker u_tff_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

// ===== dv/tb_telemetry_field_framer_stuffing.sv =====
// Self-checking testbench for the telemetry field framer with byte stuffing.
`default_nettype none

module tb_telemetry_field_framer_stuffing;
  timeunit 1ns;
  timeprecision 1ps;

  import tff_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned DrainCycles = 8;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             last;
  } stream_byte_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_axis_tvalid;
  logic               s_axis_tready;
  logic [InDataW-1:0] s_axis_tdata;
  logic               s_axis_tuser;
  logic               m_axis_tvalid;
  logic               m_axis_tready;
  logic [ByteW-1:0]   m_axis_tdata;
  logic               m_axis_tlast;

  stream_byte_t expected_bytes[$];
  int unsigned  error_count;
  int unsigned  cycle_count;
  bit           tx_idle_en;
  bit           rx_idle_en;
  int unsigned  rx_hold_left;

  telemetry_field_framer_stuffing u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  function automatic void push_byte(input logic [ByteW-1:0] b);
    stream_byte_t sb;
    sb.data = b;
    sb.last = 1'b0;
    expected_bytes.push_back(sb);
  endfunction

  function automatic void push_stuffed(input logic [ByteW-1:0] b);
    if (b == HdrByte) begin
      push_byte(EscByte);
      push_byte(EscOfHdr);
    end else if (b == EscByte) begin
      push_byte(EscByte);
      push_byte(EscOfEsc);
    end else begin
      push_byte(b);
    end
  endfunction

  // Expected byte stream of one request; tlast goes on the final byte.
  function automatic void predict_frame(input logic op, input logic [IdW-1:0] id,
                                        input logic [ValW-1:0] val);
    stream_byte_t tail_byte;
    push_byte(HdrByte);
    if (op == OpData) begin
      push_byte(id);
      push_stuffed(val[7:0]);
      push_stuffed(val[15:8]);
    end
    tail_byte = expected_bytes.pop_back();
    tail_byte.last = 1'b1;
    expected_bytes.push_back(tail_byte);
  endfunction

  task automatic send_request(input logic op, input logic [IdW-1:0] id,
                              input logic [ValW-1:0] val);
    int unsigned gap;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {val, id};
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    predict_frame(op, id, val);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 16);
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= InDataW'($urandom);
      s_axis_tuser  <= 1'($urandom);
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  // Value bytes lean towards the two marker codes so stuffing is hit often.
  function automatic logic [ByteW-1:0] pick_value_byte();
    case ($urandom_range(0, 5))
      0: return HdrByte;
      1: return EscByte;
      default: return ByteW'($urandom);
    endcase
  endfunction

  task automatic send_random_request();
    logic             op;
    logic [IdW-1:0]   id;
    logic [ValW-1:0]  val;
    op  = ($urandom_range(0, 4) == 0) ? OpTail : OpData;
    id  = ($urandom_range(0, 7) == 0) ? ($urandom_range(0, 1) ? HdrByte : EscByte)
                                      : IdW'($urandom);
    val = {pick_value_byte(), pick_value_byte()};
    send_request(op, id, val);
  endtask

  task automatic wait_drain();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (expected_bytes.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    send_request(OpTail, 8'h00, 16'h0000);
    send_request(OpData, 8'h00, 16'h0000);
    send_request(OpData, 8'hFF, 16'hFFFF);
    send_request(OpData, HdrByte, 16'h1234);
    send_request(OpData, EscByte, 16'hA55A);
    send_request(OpData, 8'h10, {HdrByte, HdrByte});
    send_request(OpData, 8'h11, {EscByte, EscByte});
    send_request(OpData, 8'h12, {HdrByte, EscByte});
    send_request(OpData, 8'h13, {EscByte, HdrByte});
    send_request(OpData, 8'h14, {8'h00, HdrByte});
    send_request(OpData, 8'h15, {EscByte, 8'hFF});
    send_request(OpData, HdrByte, {EscOfHdr, EscOfEsc});
    // tail ignores its data
    send_request(OpTail, 8'hFF, 16'hFFFF);
    send_request(OpTail, HdrByte, {HdrByte, EscByte});
    send_request(OpData, 8'hAA, 16'h5555);
    send_request(OpData, 8'h55, 16'hAAAA);
    send_request(OpTail, 8'h5A, 16'h0F0F);
    wait_drain();
  endtask

  task automatic test_random();
    repeat (390) send_random_request();
    wait_drain();
  endtask

  // Receiver holds off while requests keep coming, so the framer backs up.
  task automatic test_backpressure();
    rx_hold_left = 200;
    repeat (20) send_random_request();
    wait_drain();
  endtask

  task automatic test_streaming();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    repeat (40) send_random_request();
    wait_drain();
  endtask

  initial begin : receiver
    int unsigned burst_left;
    burst_left = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_left > 0) begin
        m_axis_tready <= 1'b0;
        rx_hold_left--;
      end else if (burst_left > 0) begin
        m_axis_tready <= 1'b0;
        burst_left--;
      end else begin
        m_axis_tready <= 1'b1;
        if (rx_idle_en && $urandom_range(0, 5) == 0) burst_left = $urandom_range(1, 16);
      end
    end
  end

  always @(posedge clk_i) begin : check_output
    stream_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h last %0b", m_axis_tdata, m_axis_tlast));
      end else begin
        want = expected_bytes.pop_front();
        if (m_axis_tdata !== want.data)
          report_mismatch($sformatf("byte %02h, want %02h", m_axis_tdata, want.data));
        if (m_axis_tlast !== want.last)
          report_mismatch($sformatf("tlast %0b, want %0b (byte %02h)",
                                    m_axis_tlast, want.last, want.data));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("telemetry_field_framer_stuffing regression: fail");
      $finish;
    end
  end

  initial begin
    error_count   = 0;
    cycle_count   = 0;
    tx_idle_en    = 1'b1;
    rx_idle_en    = 1'b1;
    rx_hold_left  = 0;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = OpData;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random();
    test_backpressure();
    test_streaming();

    repeat (DrainCycles) @(posedge clk_i);
    if (error_count == 0) begin
      $display("telemetry_field_framer_stuffing regression: pass");
    end else begin
      $display("telemetry_field_framer_stuffing regression: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
src/tff_pkg.sv
src/telemetry_field_framer_stuffing.sv
src/tff_checker.sv
dv/tb_telemetry_field_framer_stuffing.sv
